// File: hw/rtl/multi_channel_byte_pipe_unit_macros.svh
// Assertion macros shared by the byte pipe RTL.
// Depends on nothing; files that assert include it before their module.
`ifndef MULTI_CHANNEL_BYTE_PIPE_UNIT_MACROS_SVH
`define MULTI_CHANNEL_BYTE_PIPE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MCBP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("byte pipe assertion failed");
// Next-cycle implication, checked out of reset.
`define MCBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("byte pipe assertion failed");
`else
`define MCBP_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MCBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/mcbp_pkg.sv
// Package for the multi-channel byte pipe: sizes, codes and shared types.
// Used by mcbp_ctrl, the top level and the testbench; depends on nothing.
package mcbp_pkg;

    localparam int NUM_PIPES  = 8;
    localparam int PIPE_DEPTH = 256;

    localparam int ID_W     = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int HANDLE_W = 3;
    localparam int IDX_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W    = $clog2(PIPE_DEPTH);
    localparam int CNT_W    = $clog2(PIPE_DEPTH + 1);
    localparam int STORE_AW = IDX_W + PTR_W;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLOSE  = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BAD_ID  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_NO_FREE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DESC,
        SEQ_BYTE
    } seq_state_t;

    typedef struct packed {
        req_type_t         req_type;
        logic [ID_W-1:0]   pipe_id;
        logic [BYTE_W-1:0] data_byte;
        logic              run_end;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] new_handle;
        logic [BYTE_W-1:0]   read_byte;
        logic                run_end_echo;
    } result_t;

    // Per-pipe descriptor kept in the descriptor memory.
    typedef struct packed {
        logic [CNT_W-1:0] fill_count;
        logic [PTR_W-1:0] tail_index;
        logic [PTR_W-1:0] head_index;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        nxt = ptr + PTR_W'(1);
        if (ptr == PTR_W'(PIPE_DEPTH - 1)) begin
            nxt = '0;
        end
        return nxt;
    endfunction

endpackage

// File: hw/rtl/mcbp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no package needed.
module mcbp_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/mcbp_ctrl.sv
// Request sequencer for the byte pipe: active flags, descriptor and byte stores.
// Depends on mcbp_pkg, mcbp_ram and the assertion macro header.
`include "multi_channel_byte_pipe_unit_macros.svh"

module mcbp_ctrl
    import mcbp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  req_t    in_req,
    input  logic    out_free,
    output logic    res_valid,
    output result_t res
);

    seq_state_t state_reg, state_next;
    req_t       req_reg;

    logic [NUM_PIPES-1:0] active_reg, active_next;
    logic [NUM_PIPES-1:0] desc_valid_reg, desc_valid_next;

    // Descriptor memory signals.
    logic             desc_wr_en;
    logic [IDX_W-1:0] desc_wr_addr;
    desc_t            desc_wr_data;
    logic             desc_rd_en;
    logic [IDX_W-1:0] desc_rd_addr;
    logic [DESC_W-1:0] desc_rd_data;
    desc_t            desc_cur;

    // Byte store signals.
    logic                byte_wr_en;
    logic [STORE_AW-1:0] byte_wr_addr;
    logic                byte_rd_en;
    logic [STORE_AW-1:0] byte_rd_addr;
    logic [BYTE_W-1:0]   byte_rd_data;

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             accept;

    // Decisions for the request held in req_reg.
    status_t          dec_status;
    logic             create_go;
    logic             write_go;
    logic             read_go;
    logic             close_go;

    assign accept   = in_valid && in_ready;
    assign idx      = req_reg.pipe_id[IDX_W-1:0];
    assign in_range = {1'b0, req_reg.pipe_id} < (ID_W + 1)'(NUM_PIPES);
    assign desc_cur = desc_valid_reg[idx] ? desc_t'(desc_rd_data) : '0;

    mcbp_ram #(.ADDR_W(IDX_W), .DATA_W(DESC_W)) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (desc_wr_en),
        .wr_addr (desc_wr_addr),
        .wr_data (desc_wr_data),
        .rd_en   (desc_rd_en),
        .rd_addr (desc_rd_addr),
        .rd_data (desc_rd_data)
    );

    mcbp_ram #(.ADDR_W(STORE_AW), .DATA_W(BYTE_W)) u_byte_ram (
        .aclk    (aclk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_wr_addr),
        .wr_data (req_reg.data_byte),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data)
    );

    // Lowest inactive pipe.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Request decode against the descriptor read when the request was accepted.
    always_comb begin
        dec_status = ST_OK;
        create_go  = 1'b0;
        write_go   = 1'b0;
        read_go    = 1'b0;
        close_go   = 1'b0;
        if (req_reg.req_type == REQ_CREATE) begin
            if (free_found) begin
                create_go = 1'b1;
            end else begin
                dec_status = ST_NO_FREE;
            end
        end else if (!in_range) begin
            dec_status = ST_BAD_ID;
        end else if (req_reg.req_type == REQ_CLOSE) begin
            close_go = 1'b1;
        end else if (!active_reg[idx]) begin
            dec_status = ST_BAD_ID;
        end else if (req_reg.req_type == REQ_WRITE) begin
            if (desc_cur.fill_count == CNT_W'(PIPE_DEPTH)) begin
                dec_status = ST_FULL;
            end else begin
                write_go = 1'b1;
            end
        end else begin
            if (desc_cur.fill_count == '0) begin
                dec_status = ST_EMPTY;
            end else begin
                read_go = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    state_next = SEQ_DESC;
                end
            end
            SEQ_DESC: begin
                if (read_go) begin
                    state_next = SEQ_BYTE;
                end else if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_BYTE: begin
                if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Outputs: memory accesses, flag updates and the result.
    always_comb begin
        in_ready        = 1'b0;
        desc_rd_en      = 1'b0;
        desc_rd_addr    = in_req.pipe_id[IDX_W-1:0];
        desc_wr_en      = 1'b0;
        desc_wr_addr    = idx;
        desc_wr_data    = desc_cur;
        byte_wr_en      = 1'b0;
        byte_wr_addr    = {idx, desc_cur.tail_index};
        byte_rd_en      = 1'b0;
        byte_rd_addr    = {idx, desc_cur.head_index};
        active_next     = active_reg;
        desc_valid_next = desc_valid_reg;
        res_valid       = 1'b0;
        res.status       = dec_status;
        res.new_handle   = '0;
        res.read_byte    = '0;
        res.run_end_echo = req_reg.run_end;
        unique case (state_reg)
            SEQ_IDLE: begin
                in_ready   = 1'b1;
                desc_rd_en = in_valid;
            end
            SEQ_DESC: begin
                if (read_go) begin
                    // Pop: fetch the head byte and retire it from the descriptor.
                    byte_rd_en                = 1'b1;
                    desc_wr_en                = 1'b1;
                    desc_wr_data.head_index   = ptr_advance(desc_cur.head_index);
                    desc_wr_data.fill_count   = desc_cur.fill_count - CNT_W'(1);
                    desc_valid_next[idx]      = 1'b1;
                end else if (out_free) begin
                    res_valid = 1'b1;
                    if (create_go) begin
                        desc_wr_en                = 1'b1;
                        desc_wr_addr              = free_idx;
                        desc_wr_data              = '0;
                        desc_valid_next[free_idx] = 1'b1;
                        active_next[free_idx]     = 1'b1;
                        res.new_handle            = HANDLE_W'(free_idx);
                    end
                    if (close_go) begin
                        active_next[idx] = 1'b0;
                    end
                    if (write_go) begin
                        byte_wr_en              = 1'b1;
                        desc_wr_en              = 1'b1;
                        desc_wr_data.tail_index = ptr_advance(desc_cur.tail_index);
                        desc_wr_data.fill_count = desc_cur.fill_count + CNT_W'(1);
                        desc_valid_next[idx]    = 1'b1;
                    end
                end
            end
            SEQ_BYTE: begin
                res.status    = ST_OK;
                res.read_byte = byte_rd_data;
                res_valid     = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            active_reg     <= '0;
            desc_valid_reg <= '0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= in_req;
        end
    end

    `MCBP_ASSERT_NOW(a_byte_after_desc, aclk, aresetn, state_reg == SEQ_BYTE, $past(state_reg) == SEQ_DESC || $past(state_reg) == SEQ_BYTE)
    `MCBP_ASSERT_NOW(a_pop_not_empty, aclk, aresetn, byte_rd_en, desc_cur.fill_count != '0 && active_reg[idx])
    `MCBP_ASSERT_NOW(a_push_active, aclk, aresetn, byte_wr_en, active_reg[idx] && desc_cur.fill_count != CNT_W'(PIPE_DEPTH))
    `MCBP_ASSERT_NOW(a_result_busy, aclk, aresetn, res_valid, state_reg != SEQ_IDLE && out_free)
    `MCBP_ASSERT_NEXT(a_create_sets_flag, aclk, aresetn, res_valid && create_go, active_reg[$past(free_idx)])

endmodule

// File: hw/rtl/multi_channel_byte_pipe_unit.sv
// Top level of the multi-channel byte pipe: stream ports and output register.
// Depends on mcbp_pkg and mcbp_ctrl (which holds the descriptor and byte memories).
//
//  channel | direction | tdata (low bit up)                          | tlast
//  --------+-----------+---------------------------------------------+--------------
//  s_      | in        | req_type[1:0] pipe_id[5:2] data_byte[13:6]  | run_end
//  m_      | out       | status[2:0] new_handle[5:3] read_byte[13:6] | run_end_echo
//
// One item is worked on at a time. Create, close, write and every failing
// request are decided from the descriptor memory, whose read data is registered,
// and their result is then loaded; a successful read goes on to read the byte
// memory, also registered, before its result is loaded. The result sits in an
// output register, so the next item is accepted while a finished result still
// waits to be taken; a result that cannot be loaded because the register is
// still full holds the sequencer. Reset is synchronous and active low: it clears
// the active flags, the descriptor valid bits and the handshake state, and the
// byte memory needs no clearing since only written entries are ever read.
module multi_channel_byte_pipe_unit
    import mcbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // req_type, pipe_id, data_byte; top two bits unused
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status, new_handle, read_byte; top two bits zero
    output logic        m_tlast
);

    req_t    in_req;
    result_t res;
    logic    res_valid;
    logic    out_free;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    // Unpack the incoming item.
    assign in_req.req_type  = req_type_t'(s_tdata[1:0]);
    assign in_req.pipe_id   = s_tdata[5:2];
    assign in_req.data_byte = s_tdata[13:6];
    assign in_req.run_end   = s_tlast;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    mcbp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.read_byte, m_res_reg.new_handle, m_res_reg.status};
    assign m_tlast  = m_res_reg.run_end_echo;

endmodule

// File: sim/pipe_bank_sb_pkg.sv
// Scoreboard for the byte pipe testbench: a predictor of the pipe bank and the
// queue of results that the block still owes. Depends on mcbp_pkg only.
`timescale 1ns / 1ps
package pipe_bank_sb_pkg;
    import mcbp_pkg::*;

    class pipe_bank_scoreboard;
        bit                pipe_open [NUM_PIPES];
        logic [PTR_W-1:0]  head_ptr  [NUM_PIPES];
        logic [PTR_W-1:0]  tail_ptr  [NUM_PIPES];
        logic [CNT_W-1:0]  fill      [NUM_PIPES];
        logic [BYTE_W-1:0] ring      [NUM_PIPES*PIPE_DEPTH];
        result_t           results_owed [$];
        int unsigned       errors;

        function new();
            int p;
            for (p = 0; p < NUM_PIPES; p++) begin
                pipe_open[p] = 1'b0;
                head_ptr[p]  = '0;
                tail_ptr[p]  = '0;
                fill[p]      = '0;
            end
            errors = 0;
        endfunction

        // Ring indices wrap at the pipe depth, which need not be a power of two.
        function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] ptr);
            if (int'(ptr) == PIPE_DEPTH - 1) begin
                return '0;
            end
            return ptr + 1'b1;
        endfunction

        // Applies one accepted item to the pipe bank and queues the result it causes.
        function void apply_request(req_type_t kind, logic [ID_W-1:0] id,
                                    logic [BYTE_W-1:0] data, logic last);
            result_t want;
            int      p;
            int      i;
            bit      claimed;
            want.status       = ST_OK;
            want.new_handle   = '0;
            want.read_byte    = '0;
            want.run_end_echo = last;
            p       = int'(id);
            claimed = 1'b0;
            if (kind == REQ_CREATE) begin
                // The lowest closed pipe is claimed and its counters start afresh.
                want.status = ST_NO_FREE;
                for (i = 0; i < NUM_PIPES; i++) begin
                    if (!claimed && !pipe_open[i]) begin
                        claimed         = 1'b1;
                        pipe_open[i]    = 1'b1;
                        head_ptr[i]     = '0;
                        tail_ptr[i]     = '0;
                        fill[i]         = '0;
                        want.status     = ST_OK;
                        want.new_handle = HANDLE_W'(i);
                    end
                end
            end else if (p >= NUM_PIPES) begin
                want.status = ST_BAD_ID;
            end else if (kind == REQ_CLOSE) begin
                pipe_open[p] = 1'b0;
            end else if (!pipe_open[p]) begin
                want.status = ST_BAD_ID;
            end else if (kind == REQ_WRITE) begin
                if (int'(fill[p]) >= PIPE_DEPTH) begin
                    want.status = ST_FULL;
                end else begin
                    ring[p * PIPE_DEPTH + int'(tail_ptr[p])] = data;
                    tail_ptr[p] = step_ptr(tail_ptr[p]);
                    fill[p]     = fill[p] + 1'b1;
                end
            end else begin
                if (fill[p] == '0) begin
                    want.status = ST_EMPTY;
                end else begin
                    want.read_byte = ring[p * PIPE_DEPTH + int'(head_ptr[p])];
                    head_ptr[p]    = step_ptr(head_ptr[p]);
                    fill[p]        = fill[p] - 1'b1;
                end
            end
            results_owed.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compares one accepted result with the oldest result still owed.
        function void check_result(logic [15:0] data, logic last);
            result_t want;
            if (results_owed.size() == 0) begin
                $error("result with none owed: tdata %h, tlast %b", data, last);
                errors++;
                return;
            end
            want = results_owed.pop_front();
            compare_field("status", 16'(want.status), 16'(data[2:0]));
            compare_field("new_handle", 16'(want.new_handle), 16'(data[5:3]));
            compare_field("read_byte", 16'(want.read_byte), 16'(data[13:6]));
            compare_field("run_end_echo", 16'(want.run_end_echo), 16'(last));
            compare_field("tdata padding", 16'(0), 16'(data[15:14]));
        endfunction
    endclass

endpackage

// File: sim/testbench.sv
// Self-checking testbench for multi_channel_byte_pipe_unit: directed and random
// pipe requests with random stalls on both streams, checked against a scoreboard.
// Depends on mcbp_pkg, pipe_bank_sb_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
    import mcbp_pkg::*;
    import pipe_bank_sb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 140;
    localparam int          ID_SPAN       = 2 ** ID_W;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    pipe_bank_scoreboard board;
    bit                  calm;
    int unsigned         sent_items;
    int unsigned         cycle_count;

    multi_channel_byte_pipe_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long; none at all while calm.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic int pick_open_pipe();
        int picks [$];
        int p;
        for (p = 0; p < NUM_PIPES; p++) begin
            if (board.pipe_open[p]) begin
                picks.push_back(p);
            end
        end
        if (picks.size() == 0) begin
            return -1;
        end
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // Offers one item and returns once it has been accepted. The valid line is only
    // lowered when an idle gap comes first, so it is never dropped and raised in one step.
    task automatic send_request(input req_type_t kind, input logic [ID_W-1:0] id,
                                input logic [BYTE_W-1:0] data, input logic last);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, data, id, kind};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.apply_request(kind, id, data, last);
        sent_items++;
    endtask

    // Holds the sender back until the block has delivered every result owed.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.results_owed.size() != 0);
    endtask

    task automatic send_run(input req_type_t kind, input logic [ID_W-1:0] id,
                            input int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++) begin
            send_request(kind, id, BYTE_W'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic send_noise(input logic [ID_W-1:0] id);
        send_request(req_type_t'($urandom_range(0, 3)), id,
                     BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // One call as software would make it: mostly byte runs to open pipes, some
    // creates and closes, and a share of stray ids and random items.
    task automatic random_call();
        int unsigned      roll;
        int               target;
        logic [ID_W-1:0]  id;
        roll   = $urandom_range(0, 99);
        target = pick_open_pipe();
        if (target < 0 || $urandom_range(0, 9) == 0) begin
            id = ID_W'($urandom_range(0, ID_SPAN - 1));
        end else begin
            id = ID_W'(target);
        end
        if (roll < 38) begin
            send_run(REQ_WRITE, id, $urandom_range(1, 12));
        end else if (roll < 76) begin
            send_run(REQ_READ, id, $urandom_range(1, 12));
        end else if (roll < 86) begin
            send_request(REQ_CREATE, ID_W'($urandom_range(0, ID_SPAN - 1)),
                         BYTE_W'($urandom_range(0, 255)), 1'b1);
        end else if (roll < 93) begin
            send_request(REQ_CLOSE, id, BYTE_W'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_noise(ID_W'($urandom_range(0, ID_SPAN - 1)));
        end
    endtask

    // Fills one pipe to full, so its tail index wraps, offers a few bytes too many,
    // then frees some room and writes into the wrapped part of the ring.
    // Stray items go only to other ids, so the pipe stays open throughout.
    task automatic fill_and_drain();
        int          target;
        int unsigned room;
        int unsigned len;
        target = pick_open_pipe();
        if (target < 0) begin
            send_request(REQ_CREATE, '0, '0, 1'b1);
            target = pick_open_pipe();
        end
        while (int'(board.fill[target]) < PIPE_DEPTH) begin
            room = unsigned'(PIPE_DEPTH - int'(board.fill[target]));
            len  = $urandom_range(1, 40);
            if (len > room) begin
                len = room;
            end
            send_run(REQ_WRITE, ID_W'(target), len);
            if ($urandom_range(0, 4) == 0) begin
                send_noise(ID_W'((target + 1 + $urandom_range(0, ID_SPAN - 2)) % ID_SPAN));
            end
        end
        send_run(REQ_WRITE, ID_W'(target), $urandom_range(1, 3));
        send_run(REQ_READ, ID_W'(target), $urandom_range(8, 24));
        send_run(REQ_WRITE, ID_W'(target), $urandom_range(4, 8));
    endtask

    initial begin : stimulus
        int unsigned base;
        int          k;
        board      = new();
        calm       = 1'b0;
        sent_items = 0;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Requests to closed and out-of-range pipes before anything is open.
        send_request(REQ_WRITE, 4'd3, 8'hFF, 1'b1);
        send_request(REQ_READ, 4'd0, 8'h00, 1'b0);
        send_request(REQ_CLOSE, 4'd5, 8'h5A, 1'b1);
        send_request(REQ_CLOSE, 4'd15, 8'hA5, 1'b1);
        // Claim every pipe, then one create too many.
        for (k = 0; k < NUM_PIPES; k++) begin
            send_request(REQ_CREATE, ID_W'(15 - k), BYTE_W'(k * 37), 1'(k));
        end
        send_request(REQ_CREATE, 4'd0, 8'hFF, 1'b1);
        send_request(REQ_WRITE, 4'd8, 8'h5A, 1'b1);
        send_request(REQ_READ, 4'd15, 8'h00, 1'b1);
        // Empty read, then the byte extremes through one pipe.
        send_request(REQ_READ, 4'd7, 8'h00, 1'b1);
        send_request(REQ_WRITE, 4'd7, 8'h00, 1'b0);
        send_request(REQ_WRITE, 4'd7, 8'hFF, 1'b1);
        send_request(REQ_READ, 4'd7, 8'h00, 1'b0);
        send_request(REQ_READ, 4'd7, 8'hFF, 1'b1);
        // A closed pipe keeps its byte but refuses reads; a new create clears it.
        send_request(REQ_WRITE, 4'd0, 8'hAA, 1'b1);
        send_request(REQ_CLOSE, 4'd0, 8'h00, 1'b1);
        send_request(REQ_READ, 4'd0, 8'h00, 1'b1);
        send_request(REQ_CREATE, 4'd9, 8'h33, 1'b0);
        send_request(REQ_READ, 4'd0, 8'h00, 1'b1);

        wait_for_results();

        // Random calls with a calm stretch now and then, where neither side idles.
        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS / 2) begin
            calm = ((sent_items - base) % 60) >= 45;
            random_call();
        end
        calm = 1'b0;
        fill_and_drain();
        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS / 2) begin
            calm = ((sent_items - base) % 60) < 15;
            random_call();
        end
        calm = 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("multi_channel_byte_pipe_unit regression: pass");
        end else begin
            $display("multi_channel_byte_pipe_unit regression: fail");
        end
        $finish;
    end

    // Result side: ready runs of random length broken by stalls of random length.
    initial begin : result_sink
        int unsigned n;
        m_tready <= 1'b0;
        forever begin
            n = gap_len();
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge aclk);
        end
    end

    // Values are read just after the edge, before any of its updates take effect.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tlast);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("multi_channel_byte_pipe_unit regression: fail");
        $finish;
    end

endmodule

// File: multi_channel_byte_pipe_unit.f
+incdir+hw/rtl
hw/rtl/mcbp_pkg.sv
hw/rtl/mcbp_ram.sv
hw/rtl/mcbp_ctrl.sv
hw/rtl/multi_channel_byte_pipe_unit.sv
sim/pipe_bank_sb_pkg.sv
sim/testbench.sv
